>>> rtl/fccc_pkg.sv
// Package for the frame CRC-8 / CRC-16 checker: types, register map, CRC fold functions.
`timescale 1ns / 1ps
`default_nettype none

package fccc_pkg;

  localparam int unsigned AddrWidth = 3;
  localparam int unsigned DataWidth = 32;

  // Register indexes (byte address is 4 * index)
  localparam logic RegCrc16Mode  = 1'b0;
  localparam logic RegVerifyMode = 1'b1;

  localparam logic [15:0] Crc16Init = 16'hffff;
  localparam logic [15:0] Crc16Poly = 16'ha001;
  localparam logic [7:0]  Crc8Poly  = 8'h8c;

  typedef struct packed {
    logic crc16_mode;
    logic verify_mode;
  } cfg_t;

  typedef struct packed {
    logic [15:0] crc_value;
    logic        crc_ok;
    logic        frame_short;
  } result_t;

  // Reflected CRC-16 update over one byte, LSB first
  function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ Crc16Poly) : (c >> 1);
    end
    return c;
  endfunction

  // Reflected CRC-8 update over one byte, LSB first
  function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ Crc8Poly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/fccc_if.sv
// Stream interfaces for frame bytes in and CRC results out.
`timescale 1ns / 1ps
`default_nettype none

interface fccc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface fccc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] crc_value;
  logic        crc_ok;
  logic        frame_short;

  modport source (output valid, output crc_value, output crc_ok, output frame_short,
                  input ready);
  modport sink (input valid, input crc_value, input crc_ok, input frame_short,
                output ready);
endinterface

`default_nettype wire

>>> rtl/fccc_apb_regs.sv
// APB configuration registers: width mode and verify mode.
`timescale 1ns / 1ps
`default_nettype none

module fccc_apb_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [fccc_pkg::AddrWidth-1:0]   paddr,
  input  wire logic [fccc_pkg::DataWidth-1:0]   pwdata,
  output logic      [fccc_pkg::DataWidth-1:0]   prdata,
  output logic                                  pready,
  output fccc_pkg::cfg_t                        cfg
);

  logic reg_index;
  logic wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[2];
  assign wr_en     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.crc16_mode  <= 1'b1;
      cfg.verify_mode <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_index)
        fccc_pkg::RegCrc16Mode:  cfg.crc16_mode  <= pwdata[0];
        fccc_pkg::RegVerifyMode: cfg.verify_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_index)
      fccc_pkg::RegCrc16Mode:  prdata[0] = cfg.crc16_mode;
      fccc_pkg::RegVerifyMode: prdata[0] = cfg.verify_mode;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/fccc_crc_core.sv
// Frame state (CRC register, held bytes, byte count) and per-byte result logic.
`timescale 1ns / 1ps
`default_nettype none

module fccc_crc_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           step,
  input  wire logic [7:0]     data_byte,
  input  wire logic           last_byte,
  input  wire fccc_pkg::cfg_t cfg,
  output fccc_pkg::result_t   result
);

  logic [15:0] crc_reg;
  logic [7:0]  held0;
  logic [7:0]  held1;
  logic [1:0]  bytes_seen;

  logic [15:0] crc_next;
  logic [1:0]  seen_next;
  logic [7:0]  fold_in;
  logic        do_fold;
  logic [15:0] folded;
  logic [15:0] expected;
  logic [15:0] value;
  logic        short_frame;

  always_comb begin
    fold_in = cfg.verify_mode ? (cfg.crc16_mode ? held1 : held0) : data_byte;
    // verify: fold the displaced byte only once the CRC window is full
    do_fold = !cfg.verify_mode ||
              (cfg.crc16_mode ? (bytes_seen >= 2'd2) : (bytes_seen >= 2'd1));
    folded = cfg.crc16_mode ? fccc_pkg::crc16_fold(crc_reg, fold_in)
                            : {crc_reg[15:8], fccc_pkg::crc8_fold(crc_reg[7:0], fold_in)};
    crc_next  = do_fold ? folded : crc_reg;
    seen_next = (bytes_seen == 2'd3) ? bytes_seen : bytes_seen + 2'd1;

    value       = cfg.crc16_mode ? crc_next : {8'h00, crc_next[7:0]};
    short_frame = cfg.verify_mode &&
                  (cfg.crc16_mode ? (seen_next < 2'd3) : (seen_next < 2'd2));
    // trailing CRC arrives low byte first
    expected    = cfg.crc16_mode ? {data_byte, held0} : {8'h00, data_byte};

    result.crc_value   = value;
    result.frame_short = short_frame;
    result.crc_ok      = cfg.verify_mode && !short_frame && (value == expected);
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      crc_reg    <= fccc_pkg::Crc16Init;
      held0      <= '0;
      held1      <= '0;
      bytes_seen <= '0;
    end else if (step) begin
      crc_reg    <= crc_next;
      held1      <= held0;
      held0      <= data_byte;
      bytes_seen <= seen_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/frame_crc8_crc16_check.sv
// Top level of the frame CRC-8 / CRC-16 generator and checker.
`timescale 1ns / 1ps
`default_nettype none

// Frame CRC generator/checker. Bytes of a frame enter on byte_in, one per
// transfer, with last_byte set on the final one; each frame gives exactly one
// transfer on result_out, for its last byte. crc16_mode (address 0x0) selects
// reflected CRC-8 (poly 0x8c, init 0xff) or CRC-16/MODBUS (0xa001, init
// 0xffff); verify_mode (address 0x4) either folds every byte (compute) or
// holds back the trailing one or two CRC bytes (low byte first) and compares
// them with the CRC of the rest. Short frames in verify mode report
// frame_short and crc_ok low. Throughput is one byte per clock: a byte sits
// in an input register, the unrolled 8-bit CRC update and compare are
// combinational, and the result lands in an output register. The last
// byte passes through the input register and then the output register, whose
// valid drives result_out.valid. The input stalls only when a last byte
// meets a previous result that is still waiting to be taken. Write
// configuration only while the block holds no frame in flight; a write does
// not reset frame state.
module frame_crc8_crc16_check (
  input  wire logic                           clk,
  input  wire logic                           rst,
  fccc_in_if.sink                             byte_in,
  fccc_out_if.source                          result_out,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [fccc_pkg::AddrWidth-1:0] paddr,
  input  wire logic [fccc_pkg::DataWidth-1:0] pwdata,
  output logic      [fccc_pkg::DataWidth-1:0] prdata,
  output logic                                pready
);

  fccc_pkg::cfg_t    cfg;
  fccc_pkg::result_t core_result;

  // input register stage
  logic       in_valid;
  logic [7:0] in_data;
  logic       in_last;
  logic       advance;

  // output register stage
  logic              out_valid;
  fccc_pkg::result_t out_result;

  fccc_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // A non-last byte never needs the output register; a last byte waits for
  // it to be free (empty or being taken this cycle).
  assign advance = in_valid && (!in_last || !out_valid || result_out.ready);
  assign byte_in.ready = !in_valid || advance;

  fccc_crc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (in_data),
    .last_byte (in_last),
    .cfg       (cfg),
    .result    (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (byte_in.ready) begin
      in_valid <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      in_data <= byte_in.data_byte;
      in_last <= byte_in.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_last) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      out_result <= core_result;
    end
  end

  assign result_out.valid       = out_valid;
  assign result_out.crc_value   = out_result.crc_value;
  assign result_out.crc_ok      = out_result.crc_ok;
  assign result_out.frame_short = out_result.frame_short;

endmodule

`default_nettype wire

>>> verif/frame_crc8_crc16_check_tb.sv
// Self-checking testbench for the frame CRC-8 / CRC-16 generator and checker.
`timescale 1ns / 1ps

// Frames go in byte by byte through a valid/ready source. Each accepted byte
// also goes through a local copy of the CRC datapath, which queues the result
// the last byte should produce. Results coming out are matched in order.
// The run goes through all four width/verify settings, with random gaps on
// both handshakes, one long output stall, and a mode change inside a frame.
module frame_crc8_crc16_check_tb;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 4;     // two register stages plus margin
  localparam int unsigned MaxPrinted   = 40;

  // Local CRC constants, reflected form
  localparam logic [15:0] WidePoly   = 16'ha001;
  localparam logic [7:0]  NarrowPoly = 8'h8c;
  localparam logic [15:0] CrcSeed    = 16'hffff;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // APB-style configuration port
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [fccc_pkg::AddrWidth-1:0] paddr;
  logic [fccc_pkg::DataWidth-1:0] pwdata;
  logic [fccc_pkg::DataWidth-1:0] prdata;
  logic                           pready;

  fccc_in_if  byte_bus ();
  fccc_out_if result_bus ();

  frame_crc8_crc16_check uut (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_bus),
    .result_out (result_bus),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the mode bits and the frame state
  // ---------------------------------------------------------------------------
  fccc_pkg::cfg_t mode_cfg;
  logic [15:0] crc_acc;
  logic [7:0]  held [2];     // held[0] is the newest byte
  logic [1:0]  seen;         // bytes in frame, saturates at 3

  fccc_pkg::result_t pending_crc_results [$];
  logic [7:0] frame_buf [$];

  // Bookkeeping
  int unsigned mismatches      = 0;
  int unsigned bytes_sent      = 0;
  int unsigned frames_sent     = 0;
  int unsigned results_checked = 0;
  int unsigned ok_seen         = 0;
  int unsigned short_seen      = 0;
  int unsigned cycle_count     = 0;

  // Flow control knobs
  logic idle_on = 1'b1;          // random gaps on both sides
  logic offering = 1'b0;         // mirrors byte_bus.valid as last driven
  int   long_hold_cycles = 0;    // output stall request, counted down below
  int   stall_left = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < MaxPrinted)
      $display("[%0t] mismatch: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Reflected CRC, bit-serial form: each data bit enters at the LSB side.
  // In narrow mode only the low byte moves; the high byte is left alone.
  function automatic logic [15:0] crc_fold_byte(input logic [15:0] acc,
                                                input logic [7:0] b,
                                                input logic wide);
    logic [15:0] r;
    logic        fb;
    int          i;
    r = acc;
    for (i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      if (wide)
        r = {1'b0, r[15:1]} ^ (fb ? WidePoly : 16'h0000);
      else
        r[7:0] = {1'b0, r[7:1]} ^ (fb ? NarrowPoly : 8'h00);
    end
    return r;
  endfunction

  function automatic void clear_frame_state();
    crc_acc = CrcSeed;
    held[0] = 8'h00;
    held[1] = 8'h00;
    seen    = 2'd0;
  endfunction

  // Expected behavior for one accepted byte; queues a result on the last one.
  // In verify mode the byte pushed out of the hold line is the one folded,
  // so the trailing CRC bytes never enter the register.
  task automatic predict_frame_byte(input logic [7:0] b, input logic is_last);
    logic [7:0]        displaced;
    int                need;
    logic [15:0]       trailer;
    fccc_pkg::result_t want;
    displaced = mode_cfg.crc16_mode ? held[1] : held[0];
    need      = mode_cfg.crc16_mode ? 2 : 1;
    if (mode_cfg.verify_mode) begin
      if (int'(seen) >= need) crc_acc = crc_fold_byte(crc_acc, displaced, mode_cfg.crc16_mode);
    end else begin
      crc_acc = crc_fold_byte(crc_acc, b, mode_cfg.crc16_mode);
    end
    held[1] = held[0];
    held[0] = b;
    if (seen != 2'd3) seen++;
    if (is_last) begin
      want.crc_value   = mode_cfg.crc16_mode ? crc_acc : {8'h00, crc_acc[7:0]};
      want.crc_ok      = 1'b0;
      want.frame_short = 1'b0;
      if (mode_cfg.verify_mode) begin
        if (int'(seen) < need + 1) begin
          want.frame_short = 1'b1;
        end else begin
          // CRC-16 trailer arrives low byte first
          trailer = mode_cfg.crc16_mode ? {held[0], held[1]} : {8'h00, held[0]};
          want.crc_ok = (want.crc_value == trailer);
        end
      end
      pending_crc_results.push_back(want);
      frames_sent++;
      clear_frame_state();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // valid is only lowered when a gap follows, so back-to-back bytes keep it
  // high with a single assignment per step.
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int gap;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      if (offering) begin
        byte_bus.valid <= 1'b0;
        offering = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    byte_bus.valid     <= 1'b1;
    byte_bus.data_byte <= b;
    byte_bus.last_byte <= is_last;
    offering = 1'b1;
    do @(posedge clk); while (!byte_bus.ready);
    bytes_sent++;
    predict_frame_byte(b, is_last);
  endtask

  task automatic send_frame();
    int k;
    for (k = 0; k < frame_buf.size(); k++)
      send_byte(frame_buf[k], k == frame_buf.size() - 1);
  endtask

  // CRC over frame_buf under the given width, appended low byte first
  task automatic append_crc(input logic wide);
    logic [15:0] acc;
    int          k;
    acc = CrcSeed;
    for (k = 0; k < frame_buf.size(); k++) acc = crc_fold_byte(acc, frame_buf[k], wide);
    frame_buf.push_back(acc[7:0]);
    if (wide) frame_buf.push_back(acc[15:8]);
  endtask

  task automatic push_random_bytes(input int count);
    int k;
    for (k = 0; k < count; k++) frame_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  // Sender stops offering and waits for every queued result
  task automatic hold_until_drained();
    if (offering) begin
      byte_bus.valid <= 1'b0;
      offering = 1'b0;
    end
    while (pending_crc_results.size() != 0) @(posedge clk);
  endtask

  // Bytes of an open frame give no result, so allow the pipeline to empty too
  task automatic wait_block_idle();
    hold_until_drained();
    repeat (SettleCycles) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  // Each access ends idle, with psel low, so the next setup phase never lands
  // in the step that drops psel.
  task automatic write_reg(input logic idx, input logic [fccc_pkg::DataWidth-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == fccc_pkg::RegCrc16Mode) mode_cfg.crc16_mode = value[0];
    else                               mode_cfg.verify_mode = value[0];
    @(posedge clk);
  endtask

  task automatic check_reg(input logic idx);
    logic [fccc_pkg::DataWidth-1:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    want = (idx == fccc_pkg::RegCrc16Mode) ? fccc_pkg::DataWidth'(mode_cfg.crc16_mode)
                                           : fccc_pkg::DataWidth'(mode_cfg.verify_mode);
    if (prdata !== want)
      report_mismatch(idx == fccc_pkg::RegCrc16Mode ? "crc16_mode readback"
                                                    : "verify_mode readback",
                      prdata, want);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic wide, input logic check);
    wait_block_idle();
    write_reg(fccc_pkg::RegCrc16Mode, fccc_pkg::DataWidth'(wide));
    write_reg(fccc_pkg::RegVerifyMode, fccc_pkg::DataWidth'(check));
    check_reg(fccc_pkg::RegCrc16Mode);
    check_reg(fccc_pkg::RegVerifyMode);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: ready with random stalls, plus an optional long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        result_bus.ready <= 1'b0;
      end else if (long_hold_cycles != 0) begin
        long_hold_cycles <= long_hold_cycles - 1;
        result_bus.ready <= 1'b0;
      end else begin
        if (result_bus.valid && result_bus.ready)
          stall_left = idle_on ? $urandom_range(0, 15) : 0;
        if (stall_left != 0) begin
          stall_left--;
          result_bus.ready <= 1'b0;
        end else begin
          result_bus.ready <= 1'b1;
        end
      end
    end
  end

  // Result checker: every transfer is matched against the oldest expectation
  always @(posedge clk) begin
    fccc_pkg::result_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (pending_crc_results.size() == 0) begin
        report_mismatch("result with no frame pending", 32'(result_bus.crc_value), 32'h0);
      end else begin
        want = pending_crc_results.pop_front();
        results_checked++;
        if (want.crc_ok) ok_seen++;
        if (want.frame_short) short_seen++;
        if (result_bus.crc_value !== want.crc_value)
          report_mismatch("crc_value", 32'(result_bus.crc_value), 32'(want.crc_value));
        if (result_bus.crc_ok !== want.crc_ok)
          report_mismatch("crc_ok", 32'(result_bus.crc_ok), 32'(want.crc_ok));
        if (result_bus.frame_short !== want.frame_short)
          report_mismatch("frame_short", 32'(result_bus.frame_short),
                          32'(want.frame_short));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_crc_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Registers come up as CRC-16 compute; frames under that default
  task automatic test_reset_defaults();
    check_reg(fccc_pkg::RegCrc16Mode);
    check_reg(fccc_pkg::RegVerifyMode);
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    frame_buf = '{8'h31, 8'h32, 8'h33};
    send_frame();
  endtask

  // CRC-8 compute, including the all-ones and single-bit bytes
  task automatic test_compute_narrow();
    configure(1'b0, 1'b0);
    send_byte(8'hff, 1'b1);
    frame_buf = '{8'h80, 8'h01};
    send_frame();
  endtask

  // Verify mode in both widths: short frames and good trailers, plus corrupted trailers in CRC-8
  task automatic test_verify_directed();
    configure(1'b0, 1'b1);
    send_byte(8'haa, 1'b1);                  // one byte: too short for CRC-8
    frame_buf = '{8'h12, 8'h34};
    append_crc(1'b0);
    send_frame();                            // matching trailer
    frame_buf = '{8'h12, 8'h34};
    append_crc(1'b0);
    frame_buf[2] ^= 8'h01;
    send_frame();                            // trailer off by one bit

    configure(1'b1, 1'b1);
    send_byte(8'hfe, 1'b1);                  // one and two bytes: both short
    frame_buf = '{8'h01, 8'h02};
    send_frame();
    frame_buf = '{8'ha5};
    append_crc(1'b1);
    send_frame();                            // shortest valid CRC-16 frame
  endtask

  // Width flips while a frame is open; the frame state carries across
  task automatic test_mode_switch_mid_frame();
    configure(1'b1, 1'b0);
    send_byte(8'h5a, 1'b0);
    send_byte(8'hc3, 1'b0);
    wait_block_idle();
    write_reg(fccc_pkg::RegCrc16Mode, fccc_pkg::DataWidth'(1'b0));
    check_reg(fccc_pkg::RegCrc16Mode);
    send_byte(8'h0f, 1'b1);
  endtask

  // Random frames under one setting. Verify mode sends mostly well-formed
  // frames, with some corrupted by one bit and some too short.
  task automatic run_random_phase(input logic wide, input logic check,
                                  input int item_budget);
    int start_count;
    int kind;
    int pos;
    start_count = bytes_sent;
    configure(wide, check);
    while (bytes_sent - start_count < item_budget) begin
      idle_on = ($urandom_range(0, 3) != 0);
      frame_buf.delete();
      if (!check) begin
        push_random_bytes(($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                      : $urandom_range(1, 8));
      end else begin
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
          push_random_bytes($urandom_range(1, wide ? 2 : 1));
        end else begin
          push_random_bytes(($urandom_range(0, 9) == 0) ? $urandom_range(9, 20)
                                                        : $urandom_range(1, 6));
          append_crc(wide);
          if (kind <= 2) begin
            pos = $urandom_range(0, frame_buf.size() - 1);
            frame_buf[pos] ^= 8'h01 << $urandom_range(0, 7);
          end
        end
      end
      send_frame();
      if ($urandom_range(0, 15) == 0) hold_until_drained();
    end
  endtask

  // Receiver holds off for a long stretch while one- and two-byte frames keep coming,
  // so the block backs up and stalls its input
  task automatic test_output_stall();
    int k;
    configure(1'b0, 1'b1);
    idle_on = 1'b0;
    long_hold_cycles <= 400;
    for (k = 0; k < 30; k++) begin
      frame_buf.delete();
      push_random_bytes(1);
      if (k % 3 != 0) append_crc(1'b0);
      send_frame();
    end
    hold_until_drained();
    idle_on = 1'b1;
  endtask

  initial begin
    byte_bus.valid     <= 1'b0;
    byte_bus.data_byte <= 8'h00;
    byte_bus.last_byte <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    mode_cfg.crc16_mode  = 1'b1;
    mode_cfg.verify_mode = 1'b0;
    clear_frame_state();

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_compute_narrow();
    test_verify_directed();
    test_mode_switch_mid_frame();
    run_random_phase(1'b1, 1'b0, 140);
    run_random_phase(1'b0, 1'b0, 140);
    run_random_phase(1'b0, 1'b1, 140);
    run_random_phase(1'b1, 1'b1, 140);
    test_output_stall();

    hold_until_drained();
    repeat (8) @(posedge clk);
    if (pending_crc_results.size() != 0)
      report_mismatch("results never delivered", 32'(pending_crc_results.size()), 32'h0);

    $display("Sent %0d bytes in %0d frames over CRC-8/CRC-16 compute and verify settings.",
             bytes_sent, frames_sent);
    $display("Checked %0d results: %0d trailer matches, %0d short frames, %0d mismatches.",
             results_checked, ok_seen, short_seen, mismatches);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> filelist.f
rtl/fccc_pkg.sv
rtl/fccc_if.sv
rtl/fccc_apb_regs.sv
rtl/fccc_crc_core.sv
rtl/frame_crc8_crc16_check.sv
verif/frame_crc8_crc16_check_tb.sv
